FILE: design/i2cmrs_pkg.sv
// Shared types and constants for the multi-encoder I2C read sequencer.
package i2cmrs_pkg;

	// Bus master command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_SEND  = 3'd2;
	localparam logic [2:0] CMD_STOP  = 3'd3;
	localparam logic [2:0] CMD_RECV  = 3'd4;
	localparam logic [2:0] CMD_ACK   = 3'd5;
	localparam logic [2:0] CMD_NACK  = 3'd6;

	// Input event codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DONE  = 1'b1;

	// Configuration register indexes
	localparam logic CFG_ADDR_BASE = 1'b0;
	localparam logic CFG_ANGLE_REG = 1'b1;

	localparam int IDX_W = 3;

	// One result transaction
	typedef struct packed {
		logic        accepted;
		logic [2:0]  bus_cmd;
		logic [7:0]  tx_byte;
		logic        pos_valid;
		logic [1:0]  pos_index;
		logic [13:0] position;
		logic        sweep_done;
		logic        busy_res;
	} res_t;

endpackage

FILE: design/i2cmrs_if.sv
// Valid/ready channel interfaces for the sequencer's event input and command output.
interface i2cmrs_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface i2cmrs_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  bus_cmd;
	logic [7:0]  tx_byte;
	logic        pos_valid;
	logic [1:0]  pos_index;
	logic [13:0] position;
	logic        sweep_done;
	logic        busy_res;

	modport source (output valid, output accepted, output bus_cmd, output tx_byte,
		output pos_valid, output pos_index, output position, output sweep_done,
		output busy_res, input ready);
	modport sink (input valid, input accepted, input bus_cmd, input tx_byte,
		input pos_valid, input pos_index, input position, input sweep_done,
		input busy_res, output ready);
endinterface

FILE: design/i2cmrs_fsm.sv
// Sequencer state machine: per-event command generation and position capture.
module i2cmrs_fsm import i2cmrs_pkg::*; #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic [6:0] addr_base,
	input  logic [7:0] angle_reg,
	output res_t       res
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_WR_START   = 4'd1;
	localparam logic [3:0] S_WR_ADDR    = 4'd2;
	localparam logic [3:0] S_WR_REG     = 4'd3;
	localparam logic [3:0] S_WR_STOP    = 4'd4;
	localparam logic [3:0] S_RD_START   = 4'd5;
	localparam logic [3:0] S_RD_ADDR    = 4'd6;
	localparam logic [3:0] S_RD_HI      = 4'd7;
	localparam logic [3:0] S_RD_HI_ACK  = 4'd8;
	localparam logic [3:0] S_RD_LO      = 4'd9;
	localparam logic [3:0] S_RD_LO_NACK = 4'd10;
	localparam logic [3:0] S_RD_STOP    = 4'd11;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENCODERS);

	logic [3:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d, idx_inc;
	logic [7:0]       hi_q, hi_d, lo_q, lo_d;
	logic [6:0]       dev_addr;

	assign dev_addr = addr_base + 7'(idx_q);
	assign idx_inc  = idx_q + IDX_W'(1);

	// Next state and result for the event at hand
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		hi_d    = hi_q;
		lo_d    = lo_q;
		res     = '0;
		if (op == OP_START) begin
			if (state_q == S_IDLE) begin
				idx_d        = '0;
				hi_d         = '0;
				lo_d         = '0;
				res.accepted = 1'b1;
				res.bus_cmd  = CMD_START;
				state_d      = S_WR_START;
			end
		end else begin
			case (state_q)
				S_WR_START: begin
					res.bus_cmd = CMD_SEND;
					res.tx_byte = {dev_addr, 1'b0};
					state_d     = S_WR_ADDR;
				end
				S_WR_ADDR: begin
					res.bus_cmd = CMD_SEND;
					res.tx_byte = angle_reg;
					state_d     = S_WR_REG;
				end
				S_WR_REG: begin
					res.bus_cmd = CMD_STOP;
					state_d     = S_WR_STOP;
				end
				S_WR_STOP: begin
					res.bus_cmd = CMD_START;
					state_d     = S_RD_START;
				end
				S_RD_START: begin
					res.bus_cmd = CMD_SEND;
					res.tx_byte = {dev_addr, 1'b1};
					state_d     = S_RD_ADDR;
				end
				S_RD_ADDR: begin
					res.bus_cmd = CMD_RECV;
					state_d     = S_RD_HI;
				end
				S_RD_HI: begin
					hi_d        = rx_byte;
					res.bus_cmd = CMD_ACK;
					state_d     = S_RD_HI_ACK;
				end
				S_RD_HI_ACK: begin
					res.bus_cmd = CMD_RECV;
					state_d     = S_RD_LO;
				end
				S_RD_LO: begin
					lo_d        = rx_byte;
					res.bus_cmd = CMD_NACK;
					state_d     = S_RD_LO_NACK;
				end
				S_RD_LO_NACK: begin
					res.bus_cmd = CMD_STOP;
					state_d     = S_RD_STOP;
				end
				S_RD_STOP: begin
					res.pos_valid = 1'b1;
					res.pos_index = idx_q[1:0];
					res.position  = {hi_q, lo_q[5:0]};
					idx_d         = idx_inc;
					if (idx_inc < LAST_IDX) begin
						res.bus_cmd = CMD_START;
						state_d     = S_WR_START;
					end else begin
						res.sweep_done = 1'b1;
						state_d        = S_IDLE;
					end
				end
				default: begin
					// idle completions are ignored; unused codes fall back to idle
					state_d = S_IDLE;
				end
			endcase
		end
		res.busy_res = (state_d != S_IDLE);
	end

	// State update on each processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
		end else if (step) begin
			state_q <= state_d;
			idx_q   <= idx_d;
			hi_q    <= hi_d;
			lo_q    <= lo_d;
		end
	end

endmodule

FILE: design/i2c_multi_encoder_read_sequencer.sv
// Top level: input register, sequencer state machine and result register.
//
// Usage:
// - in_ch carries events: op = start request (0) or bus master completion (1),
//   with rx_byte holding the received byte on receive completions.
// - out_ch carries exactly one result transaction per event: the next bus
//   command and byte, a delivered position, sweep completion and busy status.
// - cfg_we/cfg_idx/cfg_wdata write the address base (index 0) and the angle
//   register pointer (index 1); write only while the block is idle.
// An accepted event is held in the input register and processed from there;
// its result is then held in the result register and valid on out_ch.
// Throughput: one event per cycle unless out_ch stalls; one FSM update per event.
// A stalled out_ch holds its result; the input register still takes one
// more event, then in_ch.ready drops until the result is taken.
// Reset: sequencer idle, encoder index and data cleared, address base 64,
// angle register 254, both channel stages empty.
module i2c_multi_encoder_read_sequencer import i2cmrs_pkg::*; #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	i2cmrs_in_if.sink    in_ch,
	i2cmrs_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_wdata
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rx_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res_d;
	logic       adv_s1;
	logic [6:0] addr_base_q;
	logic [7:0] angle_reg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_base_q <= 7'd64;
			angle_reg_q <= 8'd254;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ADDR_BASE: addr_base_q <= cfg_wdata[6:0];
				CFG_ANGLE_REG: angle_reg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves when the result register is free or draining
	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			op_s1 <= in_ch.op;
			rx_s1 <= in_ch.rx_byte;
		end
	end

	i2cmrs_fsm #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.op        (op_s1),
		.rx_byte   (rx_s1),
		.addr_base (addr_base_q),
		.angle_reg (angle_reg_q),
		.res       (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.accepted   = res_s2.accepted;
	assign out_ch.bus_cmd    = res_s2.bus_cmd;
	assign out_ch.tx_byte    = res_s2.tx_byte;
	assign out_ch.pos_valid  = res_s2.pos_valid;
	assign out_ch.pos_index  = res_s2.pos_index;
	assign out_ch.position   = res_s2.position;
	assign out_ch.sweep_done = res_s2.sweep_done;
	assign out_ch.busy_res   = res_s2.busy_res;

endmodule
